// File: rtl/masked_interrupt_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked interrupt controller
// Shared concurrent assertion forms, clocked and gated by the block reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_INTERRUPT_CONTROLLER_MACROS_SVH
`define MASKED_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mic_pkg.sv
// ----------------------------------------------------------------------------
// Masked interrupt controller package
// Widths, register map offsets, command codes and the decoded request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mic_pkg;

    // Default number of banks of 32 lines (legal range 1 to 4).
    localparam int NUM_BANKS_DEF = 3;

    localparam int DATA_W     = 32;
    localparam int OFS_W      = 12;
    localparam int LINE_W     = 7;
    localparam int LINE_BIT_W = 5;
    localparam int SUB_W      = 4;
    localparam int BANK_IDX_W = LINE_W - LINE_BIT_W;

    // Register offsets within a bank's 16-byte stride.
    localparam logic [SUB_W-1:0] OFS_FLAGS = 4'h0;
    localparam logic [SUB_W-1:0] OFS_RAW   = 4'h4;
    localparam logic [SUB_W-1:0] OFS_MASK  = 4'h8;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_ASSERT = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FLAGS = 2'd0,
        KIND_RAW   = 2'd1,
        KIND_MASK  = 2'd2
    } t_kind;

    // Decoded request; at most one action bit is set, and none when err is set.
    typedef struct packed {
        logic                   rd;
        logic                   wr_flags;
        logic                   wr_mask;
        logic                   set_line;
        logic                   clr_line;
        logic                   err;
        t_kind                  kind;
        logic [BANK_IDX_W-1:0]  bank;
        logic [DATA_W-1:0]      bit_mask;
    } t_dec;

endpackage

// File: rtl/mic_decode.sv
// ----------------------------------------------------------------------------
// Masked interrupt controller request decoder
// Turns a command, offset and line number into bank, register and action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_decode #(
    parameter int NUM_BANKS = mic_pkg::NUM_BANKS_DEF
) (
    input  logic [1:0]                      i_cmd,
    input  logic [mic_pkg::OFS_W-1:0]       i_reg_offset,
    input  logic [mic_pkg::LINE_W-1:0]      i_line_number,
    output mic_pkg::t_dec                   o_dec
);

    localparam int OBANK_W = mic_pkg::OFS_W - mic_pkg::SUB_W;

    logic [OBANK_W-1:0]             w_ofs_bank;
    logic [mic_pkg::SUB_W-1:0]      w_sub;
    logic                           w_ofs_ok;
    logic                           w_sub_ok;
    logic                           w_line_ok;
    logic [mic_pkg::BANK_IDX_W-1:0] w_line_bank;
    mic_pkg::t_kind                 w_kind;

    assign w_ofs_bank  = i_reg_offset[mic_pkg::OFS_W-1:mic_pkg::SUB_W];
    assign w_sub       = i_reg_offset[mic_pkg::SUB_W-1:0];
    assign w_ofs_ok    = w_ofs_bank < OBANK_W'(NUM_BANKS);
    assign w_line_bank = i_line_number[mic_pkg::LINE_W-1:mic_pkg::LINE_BIT_W];
    assign w_line_ok   = {1'b0, w_line_bank} < (mic_pkg::BANK_IDX_W + 1)'(NUM_BANKS);

    always_comb begin
        case (w_sub)
            mic_pkg::OFS_FLAGS: begin
                w_kind   = mic_pkg::KIND_FLAGS;
                w_sub_ok = 1'b1;
            end
            mic_pkg::OFS_RAW: begin
                w_kind   = mic_pkg::KIND_RAW;
                w_sub_ok = 1'b1;
            end
            mic_pkg::OFS_MASK: begin
                w_kind   = mic_pkg::KIND_MASK;
                w_sub_ok = 1'b1;
            end
            default: begin
                w_kind   = mic_pkg::KIND_FLAGS;
                w_sub_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_dec          = '0;
        o_dec.kind     = w_kind;
        o_dec.bit_mask = mic_pkg::DATA_W'(1) << i_line_number[mic_pkg::LINE_BIT_W-1:0];
        case (mic_pkg::t_cmd'(i_cmd))
            mic_pkg::CMD_READ: begin
                o_dec.bank = w_ofs_bank[mic_pkg::BANK_IDX_W-1:0];
                o_dec.rd   = w_ofs_ok && w_sub_ok;
                o_dec.err  = !(w_ofs_ok && w_sub_ok);
            end
            mic_pkg::CMD_WRITE: begin
                o_dec.bank     = w_ofs_bank[mic_pkg::BANK_IDX_W-1:0];
                o_dec.wr_flags = w_ofs_ok && w_sub_ok && (w_kind == mic_pkg::KIND_FLAGS);
                o_dec.wr_mask  = w_ofs_ok && w_sub_ok && (w_kind == mic_pkg::KIND_MASK);
                o_dec.err      = !(w_ofs_ok && w_sub_ok) || (w_kind == mic_pkg::KIND_RAW);
            end
            mic_pkg::CMD_ASSERT: begin
                o_dec.bank     = w_line_bank;
                o_dec.set_line = w_line_ok;
                o_dec.err      = !w_line_ok;
            end
            mic_pkg::CMD_CLEAR: begin
                o_dec.bank     = w_line_bank;
                o_dec.clr_line = w_line_ok;
                o_dec.err      = !w_line_ok;
            end
            default: begin
                o_dec.err = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/mic_bank_regs.sv
// ----------------------------------------------------------------------------
// Masked interrupt controller bank registers
// Raw, pending and mask words per bank, their update and the read mux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "masked_interrupt_controller_macros.svh"

module mic_bank_regs #(
    parameter int NUM_BANKS = mic_pkg::NUM_BANKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  mic_pkg::t_dec               i_dec,
    input  logic [mic_pkg::DATA_W-1:0]  i_write_data,
    output logic [mic_pkg::DATA_W-1:0]  o_read_data,
    output logic                        o_irq
);

    logic [mic_pkg::DATA_W-1:0] r_pend [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0] r_raw  [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0] r_mask [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0] n_pend [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0] n_raw  [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0] n_mask [NUM_BANKS];

    // Next state for every bank; only the selected bank changes.
    always_comb begin
        logic sel;
        for (int b = 0; b < NUM_BANKS; b++) begin
            sel       = i_en && (i_dec.bank == mic_pkg::BANK_IDX_W'(b));
            n_pend[b] = r_pend[b];
            n_raw[b]  = r_raw[b];
            n_mask[b] = r_mask[b];
            if (sel && i_dec.wr_flags) begin
                n_pend[b] = r_pend[b] & ~i_write_data;
                n_raw[b]  = r_raw[b] & ~i_write_data;
            end
            if (sel && i_dec.wr_mask) begin
                n_mask[b] = i_write_data;
                n_pend[b] = r_pend[b] | (i_write_data & r_raw[b]);
            end
            if (sel && i_dec.set_line) begin
                n_raw[b]  = r_raw[b] | i_dec.bit_mask;
                n_pend[b] = r_pend[b] | (i_dec.bit_mask & r_mask[b]);
            end
            if (sel && i_dec.clr_line) begin
                n_raw[b]  = r_raw[b] & ~i_dec.bit_mask;
                n_pend[b] = r_pend[b] & ~i_dec.bit_mask;
            end
        end
    end

    // Reads see the state before this request, the interrupt level the state after it.
    always_comb begin
        logic [mic_pkg::DATA_W-1:0] word;
        logic                       any;
        o_read_data = '0;
        any         = 1'b0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            case (i_dec.kind)
                mic_pkg::KIND_FLAGS: word = r_pend[b];
                mic_pkg::KIND_RAW:   word = r_raw[b];
                mic_pkg::KIND_MASK:  word = r_mask[b];
                default:             word = '0;
            endcase
            if (i_dec.rd && (i_dec.bank == mic_pkg::BANK_IDX_W'(b))) begin
                o_read_data = word;
            end
            any = any | (|(n_pend[b] & n_mask[b]));
        end
        o_irq = any;
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (!i_rst_n) begin
                r_pend[b] <= '0;
                r_raw[b]  <= '0;
                r_mask[b] <= '0;
            end else begin
                r_pend[b] <= n_pend[b];
                r_raw[b]  <= n_raw[b];
                r_mask[b] <= n_mask[b];
            end
        end
    end

    // A pending bit can only stand where the raw bit stands.
    for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_chk
        `MIC_ASSERT_IMP(a_pend_in_raw, i_clk, i_rst_n, 1'b1, (r_pend[gb] & ~r_raw[gb]) == '0, "pending bit set without raw bit")
    end

endmodule

// File: rtl/masked_interrupt_controller.sv
// ----------------------------------------------------------------------------
// Masked interrupt controller
// Banks of 32 interrupt lines with raw, pending and mask registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Usage. Requests arrive on the input channel (i_in_valid / o_in_ready) and
// carry a command: a bus read or write of one of the flags, raw flags or mask
// registers, or an assert or clear event on one interrupt line. Every request
// produces exactly one result on the output channel (o_out_valid /
// i_out_ready): the read data for a mapped read (zero otherwise), the
// interrupt request level after the request, and an error flag for unmapped
// offsets, writes to raw flags or line numbers beyond the last bank.
// A request is captured in the input register, then
// decoded and applied to the bank registers in one pass while its result is
// loaded into the output register. Throughput is one request per cycle while
// the receiver takes each result without stalling.
// The input register is refilled while the output register hands over its
// result, so a request is taken in the same cycle a result leaves.
// Reset clears all raw, pending and mask words and empties both registers.
// When the receiver stalls, the result waits in the output register, one
// further request waits in the input register and o_in_ready then falls.

`include "masked_interrupt_controller_macros.svh"

module masked_interrupt_controller #(
    parameter int NUM_BANKS = mic_pkg::NUM_BANKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [mic_pkg::OFS_W-1:0]       i_reg_offset,
    input  logic [mic_pkg::DATA_W-1:0]      i_write_data,
    input  logic [mic_pkg::LINE_W-1:0]      i_line_number,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mic_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_irq_out,
    output logic                            o_access_error
);

    // Input register: holds one accepted request until it can be applied.
    logic                           r_in_valid;
    logic [1:0]                     r_cmd;
    logic [mic_pkg::OFS_W-1:0]      r_reg_offset;
    logic [mic_pkg::DATA_W-1:0]     r_write_data;
    logic [mic_pkg::LINE_W-1:0]     r_line_number;

    // Output register: the finished result waiting for the receiver.
    logic                           r_out_valid;
    logic [mic_pkg::DATA_W-1:0]     r_read_data;
    logic                           r_irq;
    logic                           r_err;

    logic                           w_advance;
    mic_pkg::t_dec                  w_dec;
    logic [mic_pkg::DATA_W-1:0]     w_read_data;
    logic                           w_irq;

    // The held request is applied once the output register is free or emptying.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd         <= i_cmd;
            r_reg_offset  <= i_reg_offset;
            r_write_data  <= i_write_data;
            r_line_number <= i_line_number;
        end
    end

    mic_decode #(
        .NUM_BANKS (NUM_BANKS)
    ) u_decode (
        .i_cmd         (r_cmd),
        .i_reg_offset  (r_reg_offset),
        .i_line_number (r_line_number),
        .o_dec         (w_dec)
    );

    // The bank state changes only in the cycle the request moves to the output.
    mic_bank_regs #(
        .NUM_BANKS (NUM_BANKS)
    ) u_bank_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_dec        (w_dec),
        .i_write_data (r_write_data),
        .o_read_data  (w_read_data),
        .o_irq        (w_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_read_data <= w_read_data;
            r_irq       <= w_irq;
            r_err       <= w_dec.err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_irq_out      = r_irq;
    assign o_access_error = r_err;

    // A rejected request never returns read data.
    `MIC_ASSERT_IMP(a_err_zero_data, i_clk, i_rst_n, o_out_valid && o_access_error, o_read_data == '0, "error result carries read data")
    // An applied request always leaves a result behind.
    `MIC_ASSERT_NXT(a_adv_loads, i_clk, i_rst_n, w_advance, o_out_valid, "applied request produced no result")
    // A held request that cannot move blocks the input channel.
    `MIC_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_in_valid && !w_advance, !o_in_ready, "input taken while both registers are full")

endmodule

// File: tb/sv/tb_masked_interrupt_controller.sv
// ----------------------------------------------------------------------------
// Testbench for the masked interrupt controller
// Drives bus reads, bus writes and line events through the request channel,
// predicts each response from a private copy of the bank registers and checks
// every response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_interrupt_controller;

    localparam int NUM_BANKS   = mic_pkg::NUM_BANKS_DEF;
    localparam int STALL_LIMIT = 200;   // cycles with no handshake on either side
    localparam int TAIL_CYCLES = 8;     // settle time after the last response
    localparam int MAX_REPORTS = 10;

    // One response as the block should present it.
    typedef struct {
        logic [mic_pkg::DATA_W-1:0] read_data;
        logic                       irq;
        logic                       err;
    } t_response;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic [1:0]                  i_cmd          = '0;
    logic [mic_pkg::OFS_W-1:0]   i_reg_offset   = '0;
    logic [mic_pkg::DATA_W-1:0]  i_write_data   = '0;
    logic [mic_pkg::LINE_W-1:0]  i_line_number  = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic [mic_pkg::DATA_W-1:0]  o_read_data;
    logic                        o_irq_out;
    logic                        o_access_error;

    // Private copy of the bank registers, advanced once per accepted request.
    logic [mic_pkg::DATA_W-1:0]  pending_copy [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0]  raw_copy     [NUM_BANKS];
    logic [mic_pkg::DATA_W-1:0]  mask_copy    [NUM_BANKS];

    t_response           awaited_responses [$];

    bit                  no_idle = 1'b0;
    int                  rx_hold = 0;
    int                  stall_cycles = 0;
    int                  failures = 0;
    int                  requests_sent = 0;
    int                  responses_seen = 0;
    int                  error_responses = 0;
    int                  irq_responses = 0;

    masked_interrupt_controller #(
        .NUM_BANKS (NUM_BANKS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_line_number  (i_line_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_irq_out      (o_irq_out),
        .o_access_error (o_access_error)
    );

    always #2 i_clk = ~i_clk;

    // Byte offset of a register given its bank and its place within the stride.
    function automatic logic [mic_pkg::OFS_W-1:0] bank_reg(input int bank,
                                                           input logic [mic_pkg::SUB_W-1:0] sub);
        return mic_pkg::OFS_W'(bank * 16) | mic_pkg::OFS_W'(sub);
    endfunction

    // Applies one request to the private bank copy and returns the response
    // that the block must give for it. The interrupt level is taken after
    // the update, and it is given for rejected requests too.
    function automatic t_response apply_request(input mic_pkg::t_cmd cmd,
                                                input logic [mic_pkg::OFS_W-1:0] ofs,
                                                input logic [mic_pkg::DATA_W-1:0] data,
                                                input logic [mic_pkg::LINE_W-1:0] line);
        t_response                  rsp;
        int                         bank;
        logic [mic_pkg::SUB_W-1:0]  sub;
        bit                         mapped;
        logic [mic_pkg::DATA_W-1:0] line_bit;
        logic [mic_pkg::DATA_W-1:0] active;

        rsp.read_data = '0;
        rsp.err       = 1'b0;
        bank          = int'(ofs[mic_pkg::OFS_W-1:mic_pkg::SUB_W]);
        sub           = ofs[mic_pkg::SUB_W-1:0];
        mapped        = (bank < NUM_BANKS) &&
                        (sub == mic_pkg::OFS_FLAGS || sub == mic_pkg::OFS_RAW ||
                         sub == mic_pkg::OFS_MASK);
        line_bit      = mic_pkg::DATA_W'(1) << line[mic_pkg::LINE_BIT_W-1:0];

        case (cmd)
            mic_pkg::CMD_READ: begin
                if (!mapped) begin
                    rsp.err = 1'b1;
                end else if (sub == mic_pkg::OFS_FLAGS) begin
                    rsp.read_data = pending_copy[bank];
                end else if (sub == mic_pkg::OFS_RAW) begin
                    rsp.read_data = raw_copy[bank];
                end else begin
                    rsp.read_data = mask_copy[bank];
                end
            end
            mic_pkg::CMD_WRITE: begin
                // The raw flags register is read only, so a write to it is rejected.
                if (!mapped || sub == mic_pkg::OFS_RAW) begin
                    rsp.err = 1'b1;
                end else if (sub == mic_pkg::OFS_FLAGS) begin
                    pending_copy[bank] &= ~data;
                    raw_copy[bank]     &= ~data;
                end else begin
                    mask_copy[bank]     = data;
                    pending_copy[bank] |= data & raw_copy[bank];
                end
            end
            default: begin
                bank = int'(line[mic_pkg::LINE_W-1:mic_pkg::LINE_BIT_W]);
                if (bank >= NUM_BANKS) begin
                    rsp.err = 1'b1;
                end else if (cmd == mic_pkg::CMD_ASSERT) begin
                    raw_copy[bank] |= line_bit;
                    if ((mask_copy[bank] & line_bit) != '0) begin
                        pending_copy[bank] |= line_bit;
                    end
                end else begin
                    pending_copy[bank] &= ~line_bit;
                    raw_copy[bank]     &= ~line_bit;
                end
            end
        endcase

        active = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            active |= pending_copy[b] & mask_copy[b];
        end
        rsp.irq = (active != '0);
        return rsp;
    endfunction

    // Presents one request and waits for the block to accept it. Valid is only
    // lowered when a gap is drawn, so a back-to-back request keeps it high.
    task automatic send_request(input mic_pkg::t_cmd cmd,
                                input logic [mic_pkg::OFS_W-1:0] ofs,
                                input logic [mic_pkg::DATA_W-1:0] data,
                                input logic [mic_pkg::LINE_W-1:0] line);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_reg_offset  <= ofs;
        i_write_data  <= data;
        i_line_number <= line;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_responses.push_back(apply_request(cmd, ofs, data, line));
        requests_sent++;
    endtask

    // Holds the request channel idle until every predicted response has come.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_responses.size() != 0);
    endtask

    // After reset a flags, a raw and a mask word, taken from the first, second and last banks, must read back as zero.
    task automatic test_reset_state();
        send_request(mic_pkg::CMD_READ, bank_reg(0, mic_pkg::OFS_FLAGS), '0, '0);
        send_request(mic_pkg::CMD_READ, bank_reg(1, mic_pkg::OFS_RAW), 32'hFFFF_FFFF, 7'h7F);
        send_request(mic_pkg::CMD_READ, bank_reg(NUM_BANKS - 1, mic_pkg::OFS_MASK), '0, '0);
    endtask

    // Line events at both ends of the line range, and lines past the last bank.
    task automatic test_line_events();
        send_request(mic_pkg::CMD_WRITE, bank_reg(0, mic_pkg::OFS_MASK), 32'h8000_0001, '0);
        send_request(mic_pkg::CMD_ASSERT, '0, '0, 7'd0);
        send_request(mic_pkg::CMD_ASSERT, '0, '0, 7'd31);
        send_request(mic_pkg::CMD_CLEAR, 12'hFFF, 32'hFFFF_FFFF, 7'd31);
        send_request(mic_pkg::CMD_ASSERT, '0, '0, mic_pkg::LINE_W'(NUM_BANKS * 32 - 1));
        send_request(mic_pkg::CMD_ASSERT, '0, '0, mic_pkg::LINE_W'(NUM_BANKS * 32));
        send_request(mic_pkg::CMD_ASSERT, '0, '0, 7'd127);
        send_request(mic_pkg::CMD_CLEAR, '0, '0, 7'd127);
    endtask

    // A line raised while masked only sets its raw bit; a later mask write
    // merges it into pending, and a flags write clears both words again.
    task automatic test_mask_merge();
        send_request(mic_pkg::CMD_ASSERT, '0, '0, 7'd40);
        send_request(mic_pkg::CMD_READ, bank_reg(1, mic_pkg::OFS_RAW), '0, '0);
        send_request(mic_pkg::CMD_READ, bank_reg(1, mic_pkg::OFS_FLAGS), '0, '0);
        send_request(mic_pkg::CMD_WRITE, bank_reg(1, mic_pkg::OFS_MASK), 32'hFFFF_FFFF, '0);
        send_request(mic_pkg::CMD_READ, bank_reg(1, mic_pkg::OFS_FLAGS), '0, '0);
        send_request(mic_pkg::CMD_WRITE, bank_reg(1, mic_pkg::OFS_FLAGS), 32'hFFFF_FFFF, '0);
    endtask

    // Offsets that decode to nothing, banks past the last one and raw writes.
    task automatic test_unmapped_access();
        send_request(mic_pkg::CMD_READ, bank_reg(0, 4'hC), '0, '0);
        send_request(mic_pkg::CMD_READ, 12'h001, '0, '0);
        send_request(mic_pkg::CMD_READ, bank_reg(NUM_BANKS, mic_pkg::OFS_FLAGS), '0, '0);
        send_request(mic_pkg::CMD_WRITE, bank_reg(0, mic_pkg::OFS_RAW), 32'hFFFF_FFFF, '0);
        send_request(mic_pkg::CMD_WRITE, 12'hFFF, '0, '0);
        send_request(mic_pkg::CMD_READ, 12'hFF8, '0, '0);
    endtask

    // Mostly well formed traffic on mapped registers and lines in range with
    // random content, the rest raw noise over every field. Idling is switched
    // off for some stretches, and the sender drains the block half way.
    task automatic test_random_traffic(input int n_requests);
        int                         choice;
        int                         bank;
        logic [mic_pkg::SUB_W-1:0]  sub;
        logic [mic_pkg::DATA_W-1:0] data;
        logic [mic_pkg::OFS_W-1:0]  ofs;
        logic [mic_pkg::LINE_W-1:0] line;

        for (int k = 0; k < n_requests; k++) begin
            if (k % 100 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (k == n_requests / 2) begin
                wait_until_drained();
            end
            choice = $urandom_range(0, 99);
            bank   = $urandom_range(0, NUM_BANKS - 1);
            ofs    = mic_pkg::OFS_W'($urandom);
            line   = mic_pkg::LINE_W'($urandom_range(0, NUM_BANKS * 32 - 1));
            case ($urandom_range(0, 3))
                0:       data = mic_pkg::DATA_W'(1) << $urandom_range(0, 31);
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            if (choice < 30) begin
                send_request(mic_pkg::CMD_ASSERT, ofs, data, line);
            end else if (choice < 44) begin
                send_request(mic_pkg::CMD_CLEAR, ofs, data, line);
            end else if (choice < 60) begin
                case ($urandom_range(0, 2))
                    0:       sub = mic_pkg::OFS_FLAGS;
                    1:       sub = mic_pkg::OFS_RAW;
                    default: sub = mic_pkg::OFS_MASK;
                endcase
                send_request(mic_pkg::CMD_READ, bank_reg(bank, sub), data,
                             mic_pkg::LINE_W'($urandom));
            end else if (choice < 80) begin
                case ($urandom_range(0, 9))
                    0:       sub = mic_pkg::OFS_RAW;
                    1, 2, 3: sub = mic_pkg::OFS_FLAGS;
                    default: sub = mic_pkg::OFS_MASK;
                endcase
                send_request(mic_pkg::CMD_WRITE, bank_reg(bank, sub), data,
                             mic_pkg::LINE_W'($urandom));
            end else begin
                send_request(mic_pkg::t_cmd'($urandom_range(0, 3)), ofs, $urandom,
                             mic_pkg::LINE_W'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // Compares one response with the oldest prediction.
    task automatic check_response();
        t_response want;

        responses_seen++;
        if (awaited_responses.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("unexpected response: read_data=%08h irq=%0b err=%0b",
                         o_read_data, o_irq_out, o_access_error);
            end
        end else begin
            want = awaited_responses.pop_front();
            if (want.err)
                error_responses++;
            if (want.irq)
                irq_responses++;
            if (o_read_data !== want.read_data || o_irq_out !== want.irq ||
                o_access_error !== want.err) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display({"response %0d mismatch: read_data exp %08h got %08h, ",
                              "irq exp %0b got %0b, err exp %0b got %0b"},
                             responses_seen, want.read_data, o_read_data, want.irq, o_irq_out,
                             want.err, o_access_error);
                end
            end
        end
    endtask

    // Response side: checks each handshake and then, unless idling is switched
    // off, may draw a random stall before taking the next response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_hold     <= 0;
        end else if (i_out_ready) begin
            if (o_out_valid) begin
                check_response();
                if (!no_idle && $urandom_range(0, 5) != 0) begin
                    i_out_ready <= 1'b0;
                    rx_hold     <= $urandom_range(0, 4);
                end
            end
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            pending_copy[b] = '0;
            raw_copy[b]     = '0;
            mask_copy[b]    = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        wait_until_drained();
        test_line_events();
        test_mask_merge();
        wait_until_drained();
        test_unmapped_access();
        test_random_traffic(1525);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests and %0d responses", requests_sent, responses_seen);
        $display("%0d responses flagged an access error, %0d had the interrupt raised",
                 error_responses, irq_responses);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
